// ----- design/hkst_pkg.sv -----
package hkst_pkg;

    localparam int DEF_MAX_KEYS = 8;
    localparam int RESULT_CAP   = 8;

    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;
    localparam int ADDR_W   = 3;

    // register index, taken from paddr[2]
    localparam logic REG_HOST_LED = 1'b0;

    // op codes carried on s_tuser; the unused code means more bytes follow
    localparam logic [1:0] OP_MORE        = 2'd0;
    localparam logic [1:0] OP_END         = 2'd1;
    localparam logic [1:0] OP_END_RELEASE = 2'd2;

    localparam logic [7:0] CODE_NONE     = 8'h00;
    localparam logic [7:0] CODE_CLEAR    = 8'hFE;
    localparam logic [7:0] LED_BASE      = 8'hFC;
    localparam logic [7:0] LED_RESET     = 8'hFF;
    localparam logic [7:0] PKT_LOW_TAG   = 8'h81;
    localparam logic [7:0] PKT_HIGH_TAG  = 8'h85;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

    // function keys that own an LED
    localparam logic [7:0] FKEY_LED2 = 8'hAB;
    localparam logic [7:0] FKEY_LED3 = 8'hCB;
    localparam logic [7:0] FKEY_LED4 = 8'h8B;
    localparam logic [7:0] FKEY_LED5 = 8'hA3;
    localparam logic [7:0] FKEY_LED6 = 8'hC3;
    localparam logic [7:0] FKEY_LED7 = 8'h83;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_PRUNE,
        S_PACK,
        S_TALLY,
        S_EMIT
    } seq_state_t;

    // broadcast from the sequencer side to every cell
    typedef struct packed {
        logic       clear;
        logic       match;
        logic       append;
        logic       prune;
        logic       pack;
        logic [7:0] code;
    } cell_ctl_t;

    typedef struct packed {
        logic idle;
        logic match;
        logic prune;
        logic pack;
        logic tally;
        logic emit;
        logic last;
    } seq_ctl_t;

    // AND mask a held code applies to the LED word (bit clear = lit)
    function automatic logic [7:0] led_mask(input logic [7:0] code);
        logic [7:0] m;
        case (code)
            FKEY_LED2: m = 8'hFB;
            FKEY_LED3: m = 8'hF7;
            FKEY_LED4: m = 8'hEF;
            FKEY_LED5: m = 8'hDF;
            FKEY_LED6: m = 8'hBF;
            FKEY_LED7: m = 8'h7F;
            default:   m = 8'hFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] pkt_low(input logic [7:0] led);
        return {1'b0, led[3:0], 3'b000} | PKT_LOW_TAG;
    endfunction

    function automatic logic [7:0] pkt_high(input logic [7:0] led);
        return {1'b0, led[7:4], 3'b000} | PKT_HIGH_TAG;
    endfunction

endpackage

// ----- design/held_key_set_tracker.sv -----
// channel   | dir | signals                           | contents
// ----------+-----+-----------------------------------+--------------------------------------
// s_        | in  | s_tvalid s_tready s_tdata s_tuser | key byte; op
// m_        | out | m_tvalid m_tready m_tdata m_tlast | one held key per transfer, tlast final
// apb       | in  | psel penable pwrite paddr pwdata  | host_led_bits at 0x0
//
// An end-of-scan item is reconciled in the cell row: one scan entry per cycle is
// matched, then the unmatched codes are pruned, the gap-packing sweep runs and the
// tally is taken; then the results go out one per transfer.
// Reset empties the held list and sets the LED word to all off.
// A stalled m_tready holds the result walk; the next item is taken once the final
// result sits in the output register.
module held_key_set_tracker
    import hkst_pkg::*;
#(
    parameter int MAX_KEYS = DEF_MAX_KEYS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key_byte[7:0]
    input  logic [S_USER_W-1:0] s_tuser,   // op[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    // key_code[7:0] slot[10:8] held_count[14:11] keys_changed[15] led_bits[23:16]
    // leds_changed[24] led_packet_low[32:25] led_packet_high[40:33] zero[47:41]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    logic             s_fire;
    logic             start;
    logic             cfg_wr;
    logic [7:0]       key_byte;
    logic [1:0]       op;
    logic             byte_store;

    logic [7:0]       scan_reg [MAX_KEYS];
    logic [CNT_W-1:0] scan_count_reg;
    logic [CNT_W-1:0] scan_count_next;
    logic             scan_chg_reg;
    logic             scan_chg_next;
    logic [1:0]       host_led_reg;
    logic [7:0]       led_word_reg;
    logic [7:0]       led_word_next;
    logic [7:0]       sent_led_reg;
    logic [7:0]       sent_led_next;

    logic [CNT_W-1:0] res_held_reg;
    logic [7:0]       res_led_reg;
    logic             res_lchg_reg;
    logic             res_chg_reg;
    logic [IDX_W-1:0] last_idx_reg;

    seq_ctl_t         seq;
    logic [IDX_W-1:0] step;
    cell_ctl_t        cctl;
    logic [7:0]       cell_code [MAX_KEYS];
    logic [MAX_KEYS-1:0] cell_valid;
    logic [MAX_KEYS-1:0] cell_match;
    logic [MAX_KEYS-1:0] cell_drop;
    logic             any_match;
    logic             appended;
    logic             dropped;

    logic [CNT_W-1:0] held_sum;
    logic [7:0]       led_calc;
    logic [IDX_W-1:0] last_idx_calc;

    logic             out_free;
    logic             out_load;
    logic             m_valid_reg;
    logic             m_last_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [7:0]       key_sel;

    assign key_byte   = s_tdata;
    assign op         = s_tuser;
    assign s_tready   = seq.idle;
    assign s_fire     = s_tvalid && s_tready;
    assign start      = s_fire && (op inside {OP_END, OP_END_RELEASE});
    assign byte_store = s_fire && (key_byte != CODE_NONE) && (key_byte != CODE_CLEAR)
                     && (scan_count_reg < CNT_W'(MAX_KEYS));

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HOST_LED);
    assign prdata = (paddr[2] == REG_HOST_LED) ? {30'b0, host_led_reg} : 32'b0;

    // ---------------- cell row ----------------
    always_comb
    begin
        cctl        = '0;
        cctl.clear  = s_fire && ((key_byte == CODE_CLEAR) || (op == OP_END_RELEASE));
        cctl.match  = seq.match;
        cctl.append = seq.match && !any_match;
        cctl.prune  = seq.prune;
        cctl.pack   = seq.pack;
        cctl.code   = scan_reg[step];
    end

    genvar g;
    generate
        for (g = 0; g < MAX_KEYS; g++)
        begin : g_cell
            logic       lo_valid;
            logic       up_valid;
            logic [7:0] up_code;
            if (g == 0)
            begin : g_first
                assign lo_valid = 1'b1;
            end
            else
            begin : g_mid
                assign lo_valid = cell_valid[g-1];
            end
            if (g == MAX_KEYS - 1)
            begin : g_top
                assign up_valid = 1'b0;
                assign up_code  = CODE_NONE;
            end
            else
            begin : g_below
                assign up_valid = cell_valid[g+1];
                assign up_code  = cell_code[g+1];
            end

            hkst_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (cctl),
                .lower_valid (lo_valid),
                .upper_valid (up_valid),
                .upper_code  (up_code),
                .code        (cell_code[g]),
                .valid       (cell_valid[g]),
                .match       (cell_match[g]),
                .drop        (cell_drop[g])
            );
        end
    endgenerate

    assign any_match = |cell_match;
    assign appended  = seq.match && !any_match && !cell_valid[MAX_KEYS-1];
    assign dropped   = seq.prune && (|cell_drop);

    hkst_ctrl #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .scan_count (scan_count_reg),
        .last_idx   (last_idx_reg),
        .out_free   (out_free),
        .seq        (seq),
        .step       (step)
    );

    // ---------------- scan list ----------------
    always_ff @(posedge clk)
    begin
        if (byte_store)
        begin
            scan_reg[scan_count_reg[IDX_W-1:0]] <= key_byte;
        end
    end

    // ---------------- tally ----------------
    always_comb
    begin
        held_sum = '0;
        led_calc = LED_BASE | {6'b0, host_led_reg};
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            held_sum = held_sum + CNT_W'(cell_valid[i]);
            led_calc = led_calc & led_mask(cell_code[i]);
        end
        if (held_sum == '0)
        begin
            last_idx_calc = '0;
        end
        else if (held_sum > CNT_W'(RESULT_CAP))
        begin
            last_idx_calc = IDX_W'(RESULT_CAP - 1);
        end
        else
        begin
            last_idx_calc = IDX_W'(held_sum - CNT_W'(1));
        end
    end

    always_comb
    begin
        scan_count_next = scan_count_reg;
        scan_chg_next   = scan_chg_reg;
        led_word_next   = led_word_reg;
        sent_led_next   = sent_led_reg;
        if (byte_store)
        begin
            scan_count_next = scan_count_reg + CNT_W'(1);
        end
        if (s_fire && (key_byte == CODE_CLEAR))
        begin
            scan_chg_next = 1'b1;
        end
        if (appended || dropped)
        begin
            scan_chg_next = 1'b1;
        end
        if (cfg_wr)
        begin
            led_word_next = {led_word_reg[7:2], pwdata[1:0]};
        end
        if (seq.tally)
        begin
            scan_count_next = '0;
            scan_chg_next   = 1'b0;
            led_word_next   = led_calc;
            if (led_calc != sent_led_reg)
            begin
                sent_led_next = led_calc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_count_reg <= '0;
            scan_chg_reg   <= 1'b0;
            host_led_reg   <= 2'b11;
            led_word_reg   <= LED_RESET;
            sent_led_reg   <= 8'h00;
        end
        else
        begin
            scan_count_reg <= scan_count_next;
            scan_chg_reg   <= scan_chg_next;
            led_word_reg   <= led_word_next;
            sent_led_reg   <= sent_led_next;
            if (cfg_wr)
            begin
                host_led_reg <= pwdata[1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq.tally)
        begin
            res_held_reg <= held_sum;
            res_led_reg  <= led_calc;
            res_lchg_reg <= (led_calc != sent_led_reg);
            res_chg_reg  <= scan_chg_reg;
            last_idx_reg <= last_idx_calc;
        end
    end

    // ---------------- output register ----------------
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = seq.emit && out_free;
    assign key_sel  = (res_held_reg == '0) ? CODE_NONE : cell_code[step];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_last_reg <= seq.last;
            m_data_reg <= {7'b0,
                           pkt_high(res_led_reg),
                           pkt_low(res_led_reg),
                           res_lchg_reg,
                           res_led_reg,
                           res_chg_reg,
                           4'(res_held_reg),
                           3'(step),
                           key_sel};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // held list stays packed from cell 0 whenever no scan is being reconciled
    assert property (@(posedge clk) disable iff (!rst_n)
        seq.idle |-> ((cell_valid & (cell_valid + MAX_KEYS'(1))) == '0))
        else $error("held list has a gap while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        scan_count_reg <= CNT_W'(MAX_KEYS))
        else $error("scan count beyond list depth");

    // final result loaded returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && seq.last) |=> seq.idle)
        else $error("sequencer busy after final result");
`endif

endmodule

// ----- design/hkst_cell.sv -----
module hkst_cell
    import hkst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic       lower_valid,
    input  logic       upper_valid,
    input  logic [7:0] upper_code,
    output logic [7:0] code,
    output logic       valid,
    output logic       match,
    output logic       drop
);

    logic [7:0] code_reg;
    logic [7:0] code_next;
    logic       hit_reg;
    logic       hit_next;

    assign code  = code_reg;
    assign valid = (code_reg != CODE_NONE);
    assign match = valid && (code_reg == ctl.code);
    assign drop  = valid && !hit_reg;

    always_comb
    begin
        code_next = code_reg;
        hit_next  = hit_reg;
        if (ctl.clear)
        begin
            code_next = CODE_NONE;
            hit_next  = 1'b0;
        end
        else if (ctl.match)
        begin
            if (match)
            begin
                hit_next = 1'b1;
            end
            else if (ctl.append && !valid && lower_valid)
            begin
                // first free cell takes a code no cell holds
                code_next = ctl.code;
                hit_next  = 1'b1;
            end
        end
        else if (ctl.prune)
        begin
            hit_next = 1'b0;
            if (!hit_reg)
            begin
                code_next = CODE_NONE;
            end
        end
        else if (ctl.pack)
        begin
            // a gap pulls the code above it down one cell
            if (!valid && upper_valid)
            begin
                code_next = upper_code;
            end
            else if (valid && !lower_valid)
            begin
                code_next = CODE_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= CODE_NONE;
            hit_reg  <= 1'b0;
        end
        else
        begin
            code_reg <= code_next;
            hit_reg  <= hit_next;
        end
    end

endmodule

// ----- design/hkst_ctrl.sv -----
module hkst_ctrl
    import hkst_pkg::*;
#(
    parameter int MAX_KEYS = DEF_MAX_KEYS,
    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    localparam int CNT_W = $clog2(MAX_KEYS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] scan_count,
    input  logic [IDX_W-1:0] last_idx,
    input  logic             out_free,
    output seq_ctl_t         seq,
    output logic [IDX_W-1:0] step
);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [IDX_W-1:0] step_reg;
    logic [IDX_W-1:0] step_next;
    logic             match_done;
    logic             pack_done;

    assign step       = step_reg;
    assign match_done = (scan_count == '0)
                     || ((CNT_W'(step_reg) + CNT_W'(1)) == scan_count);
    assign pack_done  = (step_reg == IDX_W'(MAX_KEYS - 1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (start)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                if (match_done)
                begin
                    state_next = S_PRUNE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_PRUNE:
            begin
                state_next = S_PACK;
                step_next  = '0;
            end
            S_PACK:
            begin
                if (pack_done)
                begin
                    state_next = S_TALLY;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_TALLY:
            begin
                state_next = S_EMIT;
                step_next  = '0;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (step_reg == last_idx)
                    begin
                        state_next = S_IDLE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        seq       = '0;
        seq.last  = (step_reg == last_idx);
        case (state_reg)
            S_IDLE:  seq.idle  = 1'b1;
            S_MATCH: seq.match = (scan_count != '0);
            S_PRUNE: seq.prune = 1'b1;
            S_PACK:  seq.pack  = 1'b1;
            S_TALLY: seq.tally = 1'b1;
            S_EMIT:  seq.emit  = 1'b1;
            default: seq.idle  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hkst_pkg::*;

    localparam int          MAXK         = DEF_MAX_KEYS;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE       = 40;
    localparam int          RX_HOLD_LEN  = 300;
    localparam int          PHASE_ITEMS  = 62;
    localparam logic [1:0]  OP_SPARE     = 2'd3;   // unused op, behaves as "more"

    localparam logic [7:0] CODE_POOL [12] = '{FKEY_LED2, FKEY_LED3, FKEY_LED4, FKEY_LED5,
                                              FKEY_LED6, FKEY_LED7, 8'h01, 8'hFF, 8'h7F,
                                              8'h80, 8'h55, 8'hAA};

    typedef struct {
        logic [1:0] op;
        logic [7:0] key;
    } scan_item_t;

    typedef struct {
        logic [7:0] key_code;
        logic [2:0] slot;
        logic       last;
        logic [3:0] held_count;
        logic       keys_changed;
        logic [7:0] led_bits;
        logic       leds_changed;
        logic [7:0] pkt_low;
        logic [7:0] pkt_high;
    } held_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;     // key_byte[7:0]
    logic [S_USER_W-1:0] s_tuser = '0;     // op[1:0]
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    // key_code[7:0] slot[10:8] held_count[14:11] keys_changed[15] led_bits[23:16]
    // leds_changed[24] led_packet_low[32:25] led_packet_high[40:33] zero[47:41]
    wire  [M_DATA_W-1:0] m_tdata;
    wire                 m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    wire  [31:0]         prdata;
    wire                 pready;

    scan_item_t   pending_q[$];
    held_result_t expected_q[$];

    // tracker state as predicted
    logic [7:0] trk_held [MAXK];
    logic [7:0] trk_scan [MAXK];
    int         trk_scan_len;
    logic       trk_dirty;
    logic [7:0] trk_led;
    logic [7:0] trk_sent_led;
    logic [1:0] trk_host;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit rx_hold_req = 1'b0;
    int rx_hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int items_in = 0;
    int scans_closed = 0;
    int results_seen = 0;

    held_key_set_tracker u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Applies one accepted item to the predicted state; end items queue their results.
    task automatic absorb_key(input logic [1:0] op, input logic [7:0] key);
        int         i;
        int         k;
        int         u;
        int         held_n;
        int         n_out;
        bit         placed;
        bit         found;
        logic       led_diff;
        logic [7:0] led;
        held_result_t r;
        if (key == CODE_CLEAR)
        begin
            foreach (trk_held[j]) trk_held[j] = CODE_NONE;
            trk_dirty = 1'b1;
        end
        else if (key != CODE_NONE && trk_scan_len < MAXK)
        begin
            trk_scan[trk_scan_len] = key;
            trk_scan_len++;
        end
        if (op != OP_END && op != OP_END_RELEASE)
            return;
        scans_closed++;
        if (op == OP_END_RELEASE)
            foreach (trk_held[j]) trk_held[j] = CODE_NONE;

        // append codes not yet held, first free slot; drop if none free
        for (i = 0; i < trk_scan_len; i++)
        begin
            placed = 1'b0;
            for (k = 0; k < MAXK && !placed; k++)
            begin
                if (trk_held[k] == CODE_NONE)
                begin
                    trk_held[k] = trk_scan[i];
                    trk_dirty = 1'b1;
                    placed = 1'b1;
                end
                else if (trk_held[k] == trk_scan[i])
                    placed = 1'b1;
            end
        end

        // drop held codes absent from the scan; same slot is rechecked after the shift
        k = 0;
        while (k < MAXK && trk_held[k] != CODE_NONE)
        begin
            found = 1'b0;
            for (i = 0; i < trk_scan_len; i++)
                if (trk_scan[i] == trk_held[k])
                    found = 1'b1;
            if (found)
                k++;
            else
            begin
                for (u = k; u < MAXK - 1; u++)
                    trk_held[u] = trk_held[u + 1];
                trk_held[MAXK - 1] = CODE_NONE;
                trk_dirty = 1'b1;
            end
        end

        led = LED_BASE | {6'b0, trk_host};
        held_n = 0;
        while (held_n < MAXK && trk_held[held_n] != CODE_NONE)
        begin
            case (trk_held[held_n])
                FKEY_LED2: led[2] = 1'b0;
                FKEY_LED3: led[3] = 1'b0;
                FKEY_LED4: led[4] = 1'b0;
                FKEY_LED5: led[5] = 1'b0;
                FKEY_LED6: led[6] = 1'b0;
                FKEY_LED7: led[7] = 1'b0;
                default: ;
            endcase
            held_n++;
        end
        trk_led = led;
        led_diff = (led != trk_sent_led);
        if (led_diff)
            trk_sent_led = led;

        n_out = (held_n == 0) ? 1 : ((held_n > RESULT_CAP) ? RESULT_CAP : held_n);
        for (k = 0; k < n_out; k++)
        begin
            r.key_code     = (held_n == 0) ? CODE_NONE : trk_held[k];
            r.slot         = k[2:0];
            r.last         = (k + 1 == n_out);
            r.held_count   = held_n[3:0];
            r.keys_changed = trk_dirty;
            r.led_bits     = led;
            r.leds_changed = led_diff;
            r.pkt_low      = ((led & NIBBLE_MASK) << 3) | PKT_LOW_TAG;
            r.pkt_high     = ((led >> 4) << 3) | PKT_HIGH_TAG;
            expected_q.push_back(r);
        end
        trk_scan_len = 0;
        trk_dirty = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // monitor: output side first so a stray result cannot consume a fresh expectation
    always @(posedge clk)
    begin : monitor
        held_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got data %0h last %0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("key_code", want.key_code, m_tdata[7:0]);
                    check_field("slot", 8'(want.slot), 8'(m_tdata[10:8]));
                    check_field("last", 8'(want.last), 8'(m_tlast));
                    check_field("held_count", 8'(want.held_count), 8'(m_tdata[14:11]));
                    check_field("keys_changed", 8'(want.keys_changed), 8'(m_tdata[15]));
                    check_field("led_bits", want.led_bits, m_tdata[23:16]);
                    check_field("leds_changed", 8'(want.leds_changed), 8'(m_tdata[24]));
                    check_field("led_packet_low", want.pkt_low, m_tdata[32:25]);
                    check_field("led_packet_high", want.pkt_high, m_tdata[40:33]);
                    check_field("pad", 8'h00, {1'b0, m_tdata[47:41]});
                end
            end
            if (s_tvalid && s_tready)
            begin
                items_in++;
                absorb_key(s_tuser, s_tdata);
            end
        end
    end

    // driver: next item goes out once the current transfer completes
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_q[0].key;
                s_tuser  <= pending_q[0].op;
                void'(pending_q.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_req  <= 1'b0;
            rx_hold_left <= RX_HOLD_LEN;
        end
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold_req && rx_hold_left == 0
                        && $urandom_range(99) >= recv_stall_pct;
    end

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 72)
            return CODE_POOL[$urandom_range(11)];
        else if (r < 78)
            return CODE_NONE;
        else if (r < 80)
            return CODE_CLEAR;
        return 8'($urandom_range(255));
    endfunction

    task automatic push_item(input logic [1:0] op, input logic [7:0] key);
        scan_item_t it;
        it.op  = op;
        it.key = key;
        pending_q.push_back(it);
    endtask

    // mostly complete scans with random content, some stray bytes
    task automatic queue_scans(input int n);
        int added;
        int len;
        int j;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(99) < 12)
            begin
                push_item($urandom_range(1) ? OP_SPARE : OP_MORE, 8'($urandom_range(255)));
                added++;
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 6);
                for (j = 0; j < len; j++)
                    push_item(($urandom_range(15) == 0) ? OP_SPARE : OP_MORE, pick_code());
                push_item(($urandom_range(3) == 0) ? OP_END_RELEASE : OP_END,
                          ($urandom_range(2) == 0) ? CODE_NONE : pick_code());
                added += len + 1;
            end
        end
    endtask

    task automatic write_host_leds(input logic [1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_HOST_LED, 2'b00};
        pwdata  <= {30'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        trk_host = value;
        trk_led  = {trk_led[7:2], value};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(negedge clk);
        // end items may still be sweeping; let the reconcile finish
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int j;
        foreach (trk_held[i]) trk_held[i] = CODE_NONE;
        foreach (trk_scan[i]) trk_scan[i] = CODE_NONE;
        trk_scan_len = 0;
        trk_dirty    = 1'b0;
        trk_led      = LED_RESET;
        trk_sent_led = 8'h00;
        trk_host     = 2'b11;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_host_leds(2'b10);

        // directed
        push_item(OP_END, CODE_NONE);                   // nothing held: single empty result
        for (j = 0; j < 6; j++)
            push_item(OP_MORE, CODE_POOL[j]);
        push_item(OP_MORE, 8'h01);
        push_item(OP_END, 8'hFF);                       // held list full, every function-key LED lit
        push_item(OP_MORE, FKEY_LED7);
        push_item(OP_SPARE, 8'h55);                     // no free slot, code dropped
        push_item(OP_END, FKEY_LED2);                   // runs of adjacent removals
        push_item(OP_MORE, CODE_CLEAR);
        push_item(OP_MORE, CODE_NONE);
        push_item(OP_END_RELEASE, 8'h12);
        for (j = 0; j < 8; j++)
            push_item(OP_MORE, 8'h21 + 8'(j));
        push_item(OP_END, 8'h29);                       // scan list overflow
        push_item(OP_MORE, 8'h21);
        push_item(OP_END, 8'h21);                       // duplicate code within a scan
        wait_drained();

        // no idling, with a long output hold-off to back up the input
        write_host_leds(2'b00);
        queue_scans(PHASE_ITEMS);
        rx_hold_req = 1'b1;
        wait_drained();

        write_host_leds(2'b11);
        send_idle_pct = 77;
        queue_scans(PHASE_ITEMS);
        wait_drained();

        write_host_leds(2'b01);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        queue_scans(PHASE_ITEMS);
        wait_drained();

        write_host_leds(2'b10);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        queue_scans(PHASE_ITEMS);
        wait_drained();

        $display("tb: %0d key transfers, %0d scans closed, %0d results checked",
                 items_in, scans_closed, results_seen);
        $display("tb: all host LED values, four handshake mixes, %0d-cycle output hold",
                 RX_HOLD_LEN);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
